@@ hdl/ascii_integer_parser_defines.svh @@
// assertion helpers shared by the parser modules
// each module that asserts has clk_i and rst_ni in scope
`ifndef ASCII_INTEGER_PARSER_DEFINES_SVH
`define ASCII_INTEGER_PARSER_DEFINES_SVH

// same-cycle implication
`define AIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aip assertion failed");

// next-cycle implication
`define AIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aip assertion failed");

`endif

@@ hdl/aip_pkg.sv @@
`default_nettype none

package aip_pkg;

  // datapath sizes
  localparam int unsigned VALUE_WIDTH  = 64;
  localparam int unsigned OFFSET_WIDTH = 16;
  localparam int unsigned CharW        = 8;
  localparam int unsigned BaseW        = 6;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CfgIdxW      = 1;

  // queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNumberBase = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgSignedMode = 1'd1;

  // result status codes
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StOverflow = 2'd1;
  localparam logic [StatusW-1:0] StBadBase  = 2'd2;

  // radix constants
  localparam logic [BaseW-1:0] BaseAuto   = 6'd0;
  localparam logic [BaseW-1:0] BaseMin    = 6'd2;
  localparam logic [BaseW-1:0] Base8      = 6'd8;
  localparam logic [BaseW-1:0] Base10     = 6'd10;
  localparam logic [BaseW-1:0] Base16     = 6'd16;
  localparam logic [BaseW-1:0] BaseMax    = 6'd36;
  localparam logic [BaseW-1:0] DigitNone  = 6'd37;
  localparam logic [BaseW-1:0] BaseReset  = 6'd10;

  // character codes
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLa    = 8'h61;
  localparam logic [CharW-1:0] ChLz    = 8'h7a;
  localparam logic [CharW-1:0] ChUa    = 8'h41;
  localparam logic [CharW-1:0] ChUz    = 8'h5a;
  localparam logic [CharW-1:0] ChLx    = 8'h78;
  localparam logic [CharW-1:0] ChUx    = 8'h58;
  localparam logic [CharW-1:0] ChPlus  = 8'h2b;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChCr    = 8'h0d;

  // classified character handed from front to back
  typedef struct packed {
    logic             first;
    logic [BaseW-1:0] digit;
    logic             space;
    logic             plus;
    logic             minus;
    logic             zero;
    logic             x;
  } cls_t;

  // digit value in radix 36, DigitNone for anything else
  function automatic logic [BaseW-1:0] digit_of(input logic [CharW-1:0] c);
    logic [CharW-1:0] t;
    begin
      t = '0;
      if (c >= ChZero && c <= ChNine) begin
        t = c - ChZero;
      end else if (c >= ChLa && c <= ChLz) begin
        t = c - ChLa + CharW'(Base10);
      end else if (c >= ChUa && c <= ChUz) begin
        t = c - ChUa + CharW'(Base10);
      end else begin
        t = CharW'(DigitNone);
      end
      return t[BaseW-1:0];
    end
  endfunction

  // space and the control codes tab through carriage return
  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage

`default_nettype wire

@@ hdl/ascii_integer_parser.sv @@
// ASCII to integer parser, one character per transfer.
// Input channel: in_valid_i / in_stall_o with ch_i and first_i. first_i set
// starts a new conversion at offset 0; a string ends at the first character
// that is not a digit of the active base (NUL included).
// Output channel: out_valid_o / out_stall_i with value_o, end_offset_o and
// status_o (ok, range overflow, invalid base). At most one result per string.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects number_base
// or signed_mode, cfg_data_i carries the value; write only while idle.
// Throughput: one character per cycle while the queue has room; the digit
// multiply-add with its overflow check is done combinationally in the back stage.
// A transferred character is written into the 4-entry queue; the back stage
// then pops it and writes its result, if any, into the output register.
// While out_stall_i holds a result, the back stage halts; the queue keeps
// taking characters until it is full, then in_stall_o rises.
// Reset: number_base 10, unsigned mode, queue empty, no result pending,
// parser idle until a character with first_i set arrives.
`default_nettype none

module ascii_integer_parser (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      ch_i,
  input  wire logic                            first_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [63:0]                          value_o,
  output logic [15:0]                          end_offset_o,
  output logic [1:0]                           status_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [aip_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [aip_pkg::BaseW-1:0]       cfg_data_i
);
  import aip_pkg::*;

  logic [BaseW-1:0]        number_base_q;
  logic                    signed_mode_q;
  logic                    push, fifo_full, fifo_valid, pop;
  cls_t                    push_data, pop_data;
  logic [VALUE_WIDTH-1:0]  value;
  logic [OFFSET_WIDTH-1:0] end_offset;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BaseReset;
      signed_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNumberBase: number_base_q <= cfg_data_i;
        CfgSignedMode: signed_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // classify and enqueue
  aip_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .first_i     (first_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cls_o       (push_data)
  );

  aip_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .valid_o     (fifo_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  // parse and hold the result
  aip_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_base_i (number_base_q),
    .signed_mode_i (signed_mode_q),
    .fifo_valid_i  (fifo_valid),
    .fifo_data_i   (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .value_o       (value),
    .end_offset_o  (end_offset),
    .status_o      (status_o)
  );

  assign value_o      = 64'(value);
  assign end_offset_o = 16'(end_offset);

endmodule

`default_nettype wire

@@ hdl/aip_front.sv @@
`default_nettype none

module aip_front (
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [aip_pkg::CharW-1:0]  ch_i,
  input  wire logic                       first_i,
  input  wire logic                       fifo_full_i,
  output logic                            push_o,
  output aip_pkg::cls_t                   cls_o
);
  import aip_pkg::*;

  // accept whenever the queue has room
  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // classify the character independently of parser state
  always_comb begin
    cls_o.first = first_i;
    cls_o.digit = digit_of(ch_i);
    cls_o.space = is_space(ch_i);
    cls_o.plus  = (ch_i == ChPlus);
    cls_o.minus = (ch_i == ChMinus);
    cls_o.zero  = (ch_i == ChZero);
    cls_o.x     = (ch_i == ChLx) || (ch_i == ChUx);
  end

endmodule

`default_nettype wire

@@ hdl/aip_fifo.sv @@
`default_nettype none

`include "ascii_integer_parser_defines.svh"

module aip_fifo (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire aip_pkg::cls_t push_data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    pop_i,
  output aip_pkg::cls_t pop_data_o
);
  import aip_pkg::*;

  cls_t                mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]     cnt_q;

  assign full_o     = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `AIP_ASSERT_NOW(a_fifo_no_pop_empty, pop_i, cnt_q != '0)
  `AIP_ASSERT_NOW(a_fifo_no_push_full, push_i, cnt_q != (FifoAw+1)'(FifoDepth))

endmodule

`default_nettype wire

@@ hdl/aip_back.sv @@
`default_nettype none

`include "ascii_integer_parser_defines.svh"

module aip_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [aip_pkg::BaseW-1:0]     number_base_i,
  input  wire logic                          signed_mode_i,
  input  wire logic                          fifo_valid_i,
  input  wire aip_pkg::cls_t                 fifo_data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [aip_pkg::VALUE_WIDTH-1:0]    value_o,
  output logic [aip_pkg::OFFSET_WIDTH-1:0]   end_offset_o,
  output logic [aip_pkg::StatusW-1:0]        status_o
);
  import aip_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned OW = OFFSET_WIDTH;
  localparam int unsigned PW = VW + BaseW;

  // parse phases
  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhWs1      = 3'd1;
  localparam logic [2:0] PhWs2      = 3'd2;
  localparam logic [2:0] PhZeroAuto = 3'd3;
  localparam logic [2:0] PhZeroHex  = 3'd4;
  localparam logic [2:0] PhAfterX   = 3'd5;
  localparam logic [2:0] PhDigits   = 3'd6;

  localparam logic [VW-1:0] VMax = '1;
  localparam logic [VW-1:0] SMax = VMax >> 1;
  localparam logic [VW-1:0] SMin = SMax + 1'b1;
  localparam logic [OW-1:0] OMax = '1;

  logic [2:0]       phase_q, phase_d;
  logic [VW-1:0]    acc_q, acc_d;
  logic [OW-1:0]    cnt_q, cnt_d;
  logic [OW-1:0]    xpos_q, xpos_d;
  logic             neg_q, neg_d;
  logic [BaseW-1:0] base_q, base_d;
  logic             ovf_q, ovf_d;

  logic             out_valid_q;
  logic [VW-1:0]    out_val_q, res_val;
  logic [OW-1:0]    out_off_q, res_off;
  logic [StatusW-1:0] out_st_q, res_st;

  // working copies after an optional restart
  logic [2:0]       ph;
  logic [VW-1:0]    acc;
  logic [OW-1:0]    pos, xpos;
  logic             neg, ovf;
  logic [BaseW-1:0] base;

  logic             go, emit, do_digit;
  logic [BaseW-1:0] dig_base;
  logic [PW-1:0]    prod;
  logic [VW-1:0]    num_u;
  cls_t             c;

  // back side advances unless a finished result is being held
  assign pop_o = fifo_valid_i && !(out_valid_q && out_stall_i);
  assign c     = fifo_data_i;
  assign go    = pop_o && (c.first || (phase_q != PhIdle));

  always_comb begin
    ph   = c.first ? PhWs1 : phase_q;
    acc  = c.first ? '0 : acc_q;
    pos  = c.first ? '0 : cnt_q;
    xpos = c.first ? '0 : xpos_q;
    neg  = c.first ? 1'b0 : neg_q;
    ovf  = c.first ? 1'b0 : ovf_q;
    base = c.first ? '0 : base_q;
  end

  // multiply-add for the next digit, overflow is any bit above the value
  assign prod = PW'(acc) * PW'(dig_base) + PW'(c.digit);

  // saturated magnitude for the result
  assign num_u = ovf ? VMax : acc;

  always_comb begin
    phase_d  = ph;
    acc_d    = acc;
    xpos_d   = xpos;
    neg_d    = neg;
    ovf_d    = ovf;
    base_d   = base;
    cnt_d    = (pos == OMax) ? pos : pos + 1'b1;
    emit     = 1'b0;
    do_digit = 1'b0;
    dig_base = base;
    res_val  = '0;
    res_off  = pos;
    res_st   = StOk;

    // phase decisions
    unique case (ph)
      PhWs1, PhWs2: begin
        if (c.space) begin
          phase_d = ph;
        end else if (ph == PhWs1 && signed_mode_i && (c.plus || c.minus)) begin
          neg_d   = c.minus;
          phase_d = PhWs2;
        end else if (number_base_i == BaseAuto || number_base_i == Base16) begin
          if (c.zero) begin
            phase_d = (number_base_i == BaseAuto) ? PhZeroAuto : PhZeroHex;
          end else begin
            dig_base = (number_base_i == BaseAuto) ? Base10 : Base16;
            do_digit = 1'b1;
          end
        end else if (number_base_i < BaseMin || number_base_i > BaseMax) begin
          emit    = 1'b1;
          res_st  = StBadBase;
          phase_d = PhIdle;
        end else begin
          dig_base = number_base_i;
          do_digit = 1'b1;
        end
      end
      PhZeroAuto, PhZeroHex: begin
        if (c.x) begin
          xpos_d  = pos;
          phase_d = PhAfterX;
        end else begin
          dig_base = (ph == PhZeroAuto) ? Base8 : Base16;
          do_digit = 1'b1;
        end
      end
      PhAfterX: begin
        if (c.digit < Base16) begin
          dig_base = Base16;
          do_digit = 1'b1;
        end else begin
          emit    = 1'b1;
          res_off = xpos;
          phase_d = PhIdle;
        end
      end
      PhDigits: begin
        do_digit = 1'b1;
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    // digit consumption or end of number
    if (do_digit) begin
      base_d  = dig_base;
      phase_d = PhDigits;
      if (c.digit >= dig_base) begin
        emit    = 1'b1;
        phase_d = PhIdle;
        if (!signed_mode_i) begin
          res_val = num_u;
          res_st  = ovf ? StOverflow : StOk;
        end else if (!num_u[VW-1]) begin
          res_val = neg ? (VW'(0) - num_u) : num_u;
        end else if (neg && num_u == SMin) begin
          res_val = SMin;
        end else begin
          res_val = SMax;
          res_st  = StOverflow;
        end
      end else if (!ovf) begin
        if (prod[PW-1:VW] != '0) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = prod[VW-1:0];
        end
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      acc_q   <= '0;
      cnt_q   <= '0;
      xpos_q  <= '0;
      neg_q   <= 1'b0;
      base_q  <= '0;
      ovf_q   <= 1'b0;
    end else if (go) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      xpos_q  <= xpos_d;
      neg_q   <= neg_d;
      base_q  <= base_d;
      ovf_q   <= ovf_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (go && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_val_q <= res_val;
      out_off_q <= res_off;
      out_st_q  <= res_st;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = out_val_q;
  assign end_offset_o = out_off_q;
  assign status_o     = out_st_q;

  `AIP_ASSERT_NOW(a_back_no_overwrite, go && emit, !(out_valid_q && out_stall_i))
  `AIP_ASSERT_NEXT(a_back_idle_after_end, go && emit, phase_q == PhIdle)

endmodule

`default_nettype wire
